// File: design/lrum_pkg.sv
// Package for the LRU key to slot mapper.
// Holds field widths, default sizing and reset constants; depends on nothing.
`default_nettype none

package lrum_pkg;

  // Fixed field widths of the request and result channels.
  localparam int KEY_W      = 64;
  localparam int CAP_W      = 7;
  localparam int SLOT_OUT_W = 6;

  // Default number of slots in the tag table.
  localparam int DEFAULT_SLOTS = 64;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage : lrum_pkg

`default_nettype wire

// File: design/lru_key_to_slot_mapper.sv
// Top level of the LRU key to slot mapper: a fully associative tag table.
// Depends on lrum_pkg for widths and reset constants.
//
// Usage:
//   Request channel (in_valid / in_ready / lookup_key) carries one 64-bit key
//   per request. Result channel (out_valid / out_ready / slot_index / is_new)
//   returns one result per request, in order. slot_index is the slot that
//   holds or now holds the key; is_new is 1 when the key was newly assigned.
//   Configuration channel (cfg_valid / cfg_ready / cfg_capacity) writes the
//   capacity register; it is always ready. The user must write it only while
//   idle; the block itself does not enforce this. A request is registered on
//   acceptance; once the result register is free or being emptied, the key is
//   compared against every filled slot in parallel, the slot and recency ranks
//   are updated and the result is registered. One request is taken every
//   cycle while the receiver keeps up, through the parallel compare and
//   rank update over all slots. When the receiver stalls, the result register
//   holds, the pending request waits in the input register and in_ready falls
//   once both are full. Synchronous reset empties the table (fill count zero),
//   drops any request and result in flight and sets capacity to 64. Slot keys
//   and ranks have no reset; only filled slots are ever read.
`default_nettype none

module lru_key_to_slot_mapper #(
  parameter int SLOTS = lrum_pkg::DEFAULT_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lrum_pkg::KEY_W-1:0]     lookup_key,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lrum_pkg::SLOT_OUT_W-1:0]     slot_index,
  output logic                                is_new,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lrum_pkg::CAP_W-1:0]     cfg_capacity
);

  import lrum_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PAD_W = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;

  // Table state.
  logic [KEY_W-1:0] keys  [SLOTS];
  logic [IDX_W-1:0] ranks [SLOTS];
  logic [CNT_W-1:0] filled_count;
  logic [CAP_W-1:0] capacity;

  // Input register and result register.
  logic             req_valid;
  logic [KEY_W-1:0] req_key;
  logic             advance;

  // Per-slot match and selection vectors.
  logic [SLOTS-1:0] filled_vec;
  logic [SLOTS-1:0] hit_vec;
  logic [SLOTS-1:0] lru_vec;
  logic [SLOTS-1:0] target_vec;
  logic             hit;
  logic             fill;
  logic [IDX_W-1:0] target_slot;
  logic [IDX_W-1:0] target_rank;
  logic [IDX_W-1:0] top_rank;
  logic [CMP_W-1:0] filled_wide;
  logic [CMP_W-1:0] cap_wide;
  logic [PAD_W-1:0] slot_pad;

  // Configuration register: always ready; the user must write it only while the block is idle, not enforced here.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_capacity;
    end
  end

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied this cycle.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_key <= lookup_key;
    end
  end

  // Parallel compare over the filled slots, and location of the LRU slot.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      filled_vec[i] = CNT_W'(i) < filled_count;
      hit_vec[i]    = filled_vec[i] && (keys[i] == req_key);
      lru_vec[i]    = filled_vec[i] && (ranks[i] == '0);
    end
  end

  // The effective capacity is the register clamped to 1..SLOTS.
  assign filled_wide = CMP_W'(filled_count);
  assign cap_wide    = CMP_W'(capacity);
  assign hit         = |hit_vec;
  assign fill        = !hit && (filled_wide < cap_wide || cap_wide == '0 && filled_count == '0)
                       && (filled_wide < CMP_W'(SLOTS));

  // Target slot: the matching slot, the next free slot, or the LRU victim.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (hit) begin
        target_vec[i] = hit_vec[i];
      end else if (fill) begin
        target_vec[i] = CNT_W'(i) == filled_count;
      end else begin
        target_vec[i] = lru_vec[i];
      end
    end
  end

  // One-hot to index and rank of the target slot.
  always_comb begin
    target_slot = '0;
    target_rank = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (target_vec[i]) begin
        target_slot = target_slot | IDX_W'(i);
        target_rank = target_rank | ranks[i];
      end
    end
  end

  // A touched slot becomes the most recent; a new fill takes the next rank.
  assign top_rank = fill ? IDX_W'(filled_count) : IDX_W'(filled_count - 1'b1);

  // Per-slot key and rank update.
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (advance && target_vec[g]) begin
        keys[g]  <= hit ? keys[g] : req_key;
        ranks[g] <= top_rank;
      end else if (advance && !fill && filled_vec[g] && ranks[g] > target_rank) begin
        ranks[g] <= ranks[g] - 1'b1;
      end
    end
  end

  // Fill count grows only when a free slot is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
    end else if (advance && fill) begin
      filled_count <= filled_count + 1'b1;
    end
  end

  // Result register.
  assign slot_pad = PAD_W'(target_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_index <= slot_pad[SLOT_OUT_W-1:0];
      is_new     <= !hit;
    end
  end

endmodule : lru_key_to_slot_mapper

`default_nettype wire

// File: tb/sv/lru_key_to_slot_mapper_test.sv
// Self-checking testbench for the LRU key to slot mapper.
// Drives lookup requests and capacity writes and checks every result against a model.
// Depends on lrum_pkg and the lru_key_to_slot_mapper top level.
`timescale 1ns / 100ps

module lru_key_to_slot_mapper_test;
  import lrum_pkg::*;

  localparam int TABLE_SLOTS  = DEFAULT_SLOTS;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  fresh;
  } mapping_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KEY_W-1:0]      lookup_key = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  is_new;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_capacity = '0;

  // Set for one phase to run both sides without any idling.
  logic steady = 1'b0;

  logic [KEY_W-1:0] pending_keys[$];
  mapping_t         expected_maps[$];
  int unsigned      mismatches = 0;

  // Model state: keys held per slot, recency ranks and the fill count.
  logic [KEY_W-1:0] held_key[TABLE_SLOTS];
  int unsigned      age_rank[TABLE_SLOTS];
  int unsigned      used_slots = 0;
  logic [CAP_W-1:0] cap_setting = CAP_RESET;

  always #1 clk = ~clk;

  lru_key_to_slot_mapper #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .lookup_key(lookup_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .slot_index(slot_index),
    .is_new(is_new),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  // Queue helpers: append at the tail, take from the head.
  function automatic void add_key(input logic [KEY_W-1:0] key);
    pending_keys.insert(pending_keys.size(), key);
  endfunction

  function automatic logic [KEY_W-1:0] take_key();
    logic [KEY_W-1:0] key;
    key = pending_keys[0];
    pending_keys.delete(0);
    return key;
  endfunction

  function automatic void add_expected(input mapping_t m);
    expected_maps.insert(expected_maps.size(), m);
  endfunction

  function automatic mapping_t take_expected();
    mapping_t m;
    m = expected_maps[0];
    expected_maps.delete(0);
    return m;
  endfunction

  // Capacity in force: zero acts as one, anything above the slot count saturates.
  function automatic int unsigned active_capacity();
    if (cap_setting == '0) return 1;
    if (cap_setting > TABLE_SLOTS) return TABLE_SLOTS;
    return 32'(cap_setting);
  endfunction

  // Move slot s to the most recently used rank, closing the gap it leaves.
  function automatic void make_newest(input int unsigned s);
    int unsigned r;
    r = age_rank[s];
    for (int unsigned i = 0; i < used_slots; i++) begin
      if (age_rank[i] > r) age_rank[i] = age_rank[i] - 1;
    end
    age_rank[s] = used_slots - 1;
  endfunction

  // Look a key up in the model table and update it the way the block does.
  function automatic mapping_t map_key(input logic [KEY_W-1:0] key);
    mapping_t    res;
    int unsigned s;
    bit          hit;
    bit          found;
    s = 0;
    hit = 1'b0;
    for (int unsigned i = 0; i < used_slots; i++) begin
      if (!hit && held_key[i] == key) begin
        hit = 1'b1;
        s = i;
      end
    end
    if (hit) begin
      make_newest(s);
    end else if (used_slots < active_capacity()) begin
      s = used_slots;
      held_key[s] = key;
      age_rank[s] = used_slots;
      used_slots++;
    end else begin
      // Table full: the least recently used slot of all filled ones is reused.
      found = 1'b0;
      for (int unsigned i = 0; i < used_slots; i++) begin
        if (!found && age_rank[i] == 0) begin
          found = 1'b1;
          s = i;
        end
      end
      held_key[s] = key;
      make_newest(s);
    end
    res.slot = SLOT_OUT_W'(s);
    res.fresh = !hit;
    return res;
  endfunction

  // Request driver: predicts each accepted request and offers the next one.
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) add_expected(map_key(lookup_key));
      if (!in_valid || in_ready) begin
        if (pending_keys.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          lookup_key <= take_key();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver, including one long hold-off to back the block up.
  always @(posedge clk) begin : check_results
    mapping_t    want;
    int unsigned results_seen;
    int unsigned hold_cycles;
    bit          held;
    if (rst) begin
      out_ready <= 1'b0;
      results_seen = 0;
      hold_cycles = 0;
      held = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_maps.size() == 0) begin
          $error("result with no request outstanding: slot_index %0d, is_new %0b",
                 slot_index, is_new);
          mismatches++;
        end else begin
          want = take_expected();
          if (slot_index !== want.slot) begin
            $error("slot_index mismatch: expected %0d, got %0d", want.slot, slot_index);
            mismatches++;
          end
          if (is_new !== want.fresh) begin
            $error("is_new mismatch: expected %0b, got %0b", want.fresh, is_new);
            mismatches++;
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_cycles = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Watchdog: ends the run if no channel moves for too long.
  always @(posedge clk) begin : watchdog
    int unsigned quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Wait until every request has been taken and answered, then let the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_keys.size() != 0 || in_valid || expected_maps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register through its own channel; only called while idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_capacity <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = value;
  endtask

  // Queue n lookups: mostly keys from a working set a little larger than the
  // capacity, so hits, fills and evictions all occur, plus fresh and extreme keys.
  task automatic queue_lookups(input int unsigned n);
    logic [KEY_W-1:0] working_set[$];
    int unsigned      set_size;
    int unsigned      pick;
    set_size = active_capacity() + $urandom_range(0, 8);
    repeat (set_size) working_set.insert(working_set.size(), {$urandom, $urandom});
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 75)
        add_key(working_set[$urandom_range(0, set_size - 1)]);
      else if (pick < 97)
        add_key({$urandom, $urandom});
      else
        add_key({KEY_W{pick[0]}});
    end
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n);
    write_capacity(cap);
    queue_lookups(n);
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: extreme keys, repeats that hit, and alternating bit patterns.
    pending_keys = '{64'h0, '1, 64'h0, 64'h8000_0000_0000_0000,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '1, 64'h1};
    wait_idle();

    // Capacity lowered below the fill count: misses evict among all filled slots.
    write_capacity(7'd1);
    pending_keys = '{64'h5555_5555_5555_5555, 64'h1234, 64'h1234, 64'h0};
    wait_idle();

    // Capacity zero behaves as one.
    write_capacity('0);
    pending_keys = '{64'h7, 64'h8, 64'h7};
    wait_idle();

    // Capacity above the slot count saturates; the table grows again.
    write_capacity('1);
    pending_keys = '{64'h9, 64'hA};
    wait_idle();

    // Random phases over a spread of capacity settings.
    run_phase('1, 260);
    run_phase(7'd64, 200);
    run_phase(7'd5, 150);
    run_phase(CAP_W'($urandom_range(1, 64)), 200);
    run_phase('0, 120);
    run_phase(7'd2, 150);
    run_phase(CAP_W'($urandom_range(65, 127)), 200);
    @(posedge clk);
    steady <= 1'b1;
    run_phase(7'd64, 220);

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: lru_key_to_slot_mapper.f
design/lrum_pkg.sv
design/lru_key_to_slot_mapper.sv
tb/sv/lru_key_to_slot_mapper_test.sv
